/* design/ntsel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsel_pkg
// Shared constants and types for the next-event timer selector.
// ----------------------------------------------------------------------------
package ntsel_pkg;

	localparam int TIME_W       = 63;
	localparam int MASK_W       = 8;
	localparam int CHAN_FIELD_W = 3;
	localparam int CHANNELS_DEF = 8;

	localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_RESET = TIME_W'(100);

	localparam logic FUNC_ARM     = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic start;    // clear running minimum and tie set
		logic sample;   // read data of one entry is on the bus
		logic present;  // that entry holds an armed deadline
	} scan_ctl_t;

endpackage

/* design/ntsel_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsel_ram
// Single-port synchronous RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module ntsel_ram #(
	parameter int WIDTH = ntsel_pkg::TIME_W,
	parameter int DEPTH = ntsel_pkg::CHANNELS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* design/ntsel_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsel_scan
// Running minimum over a stream of deadlines, with the set of tied channels.
// ----------------------------------------------------------------------------
module ntsel_scan #(
	parameter int CHANNELS = ntsel_pkg::CHANNELS_DEF,
	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ntsel_pkg::scan_ctl_t           ctl,
	input  logic [CH_W-1:0]                index,
	input  logic [ntsel_pkg::TIME_W-1:0]   data,
	output logic [ntsel_pkg::TIME_W-1:0]   best,
	output logic [CHANNELS-1:0]            ties
);

	logic [ntsel_pkg::TIME_W-1:0] best_q;
	logic [CHANNELS-1:0]          ties_q;
	logic [ntsel_pkg::TIME_W-1:0] eff;
	logic [CHANNELS-1:0]          onehot;

	// a disarmed entry counts as the largest time and never joins the tie set
	assign eff    = ctl.present ? data : ntsel_pkg::TIME_MAX;
	assign onehot = CHANNELS'(1) << index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= ntsel_pkg::TIME_MAX;
			ties_q <= '0;
		end else if (ctl.start) begin
			best_q <= ntsel_pkg::TIME_MAX;
			ties_q <= '0;
		end else if (ctl.sample) begin
			if (eff < best_q) begin
				best_q <= eff;
				ties_q <= onehot;
			end else if (eff == best_q && eff != ntsel_pkg::TIME_MAX) begin
				ties_q <= ties_q | onehot;
			end
		end
	end

	assign best = best_q;
	assign ties = ties_q;

endmodule

/* design/next_event_timer_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_event_timer_selector
// One-shot event timer over CHANNELS deadlines held in a RAM, one global time.
// ----------------------------------------------------------------------------
// Arm: result registered at the accepting edge.
// Advance: one RAM read per channel in S_SCAN, then S_DRAIN and S_DONE before the result;
//   the single RAM port and the serial scan set the pace.
// One request in flight; a new one is taken only once the previous result leaves,
//   at the earliest in the cycle that result is accepted.
// Reset: global time 100, all channels disarmed through per-entry armed flags,
//   no clearing pass; the RAM itself is not cleared.
module next_event_timer_selector #(
	parameter int CHANNELS = ntsel_pkg::CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic                                  func,
	input  logic [ntsel_pkg::CHAN_FIELD_W-1:0]    channel,
	input  logic [ntsel_pkg::TIME_W-1:0]          delta_ns,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output logic [ntsel_pkg::TIME_W-1:0]          now_time,
	output logic [ntsel_pkg::MASK_W-1:0]          fired_mask,
	output logic                                  idle
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

	state_t                         state_q;
	logic [CH_W-1:0]                cnt_q;
	logic                           rd_valid_s1;
	logic                           present_s1;
	logic [CH_W-1:0]                idx_s1;
	logic [ntsel_pkg::TIME_W-1:0]   global_time_q;
	logic [CHANNELS-1:0]            armed_q;
	logic                           rsp_valid_q;
	logic [ntsel_pkg::TIME_W-1:0]   now_time_q;
	logic [ntsel_pkg::MASK_W-1:0]   fired_q;
	logic                           idle_q;

	logic                           out_free;
	logic                           accept;
	logic                           arm_hit;
	logic                           commit;
	logic                           none_armed;
	logic [CH_W-1:0]                ch_idx;
	logic [ntsel_pkg::TIME_W:0]     sum;
	logic [ntsel_pkg::TIME_W-1:0]   arm_data;
	logic [CH_W-1:0]                ram_addr;
	logic [ntsel_pkg::TIME_W-1:0]   ram_rdata;
	logic [ntsel_pkg::TIME_W-1:0]   best;
	logic [CHANNELS-1:0]            ties;
	logic [ntsel_pkg::MASK_W-1:0]   fired_c;
	ntsel_pkg::scan_ctl_t           scan_ctl;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign ch_idx    = CH_W'(channel);
	assign arm_hit   = accept && (func == ntsel_pkg::FUNC_ARM) && (int'(channel) < CHANNELS);

	// saturating deadline; both operands below 2^63 so the carry flags overflow
	assign sum      = {1'b0, global_time_q} + {1'b0, delta_ns};
	assign arm_data = sum[ntsel_pkg::TIME_W] ? ntsel_pkg::TIME_MAX
	                                         : sum[ntsel_pkg::TIME_W-1:0];

	assign ram_addr   = (state_q == S_SCAN) ? cnt_q : ch_idx;
	assign commit     = (state_q == S_DONE) && out_free;
	assign none_armed = (best == ntsel_pkg::TIME_MAX);

	assign scan_ctl.start   = accept && (func == ntsel_pkg::FUNC_ADVANCE);
	assign scan_ctl.sample  = rd_valid_s1;
	assign scan_ctl.present = present_s1;

	ntsel_ram #(
		.WIDTH (ntsel_pkg::TIME_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (arm_hit),
		.re    (state_q == S_SCAN),
		.addr  (ram_addr),
		.wdata (arm_data),
		.rdata (ram_rdata)
	);

	ntsel_scan #(
		.CHANNELS (CHANNELS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.index  (idx_s1),
		.data   (ram_rdata),
		.best   (best),
		.ties   (ties)
	);

	// fire bits beyond the eighth channel are dropped from the result
	for (genvar i = 0; i < ntsel_pkg::MASK_W; i++) begin : g_fired
		if (i < CHANNELS) begin : g_on
			assign fired_c[i] = ties[i];
		end else begin : g_off
			assign fired_c[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rd_valid_s1   <= 1'b0;
			present_s1    <= 1'b0;
			idx_s1        <= '0;
			global_time_q <= ntsel_pkg::TIME_RESET;
			armed_q       <= '0;
			rsp_valid_q   <= 1'b0;
			now_time_q    <= '0;
			fired_q       <= '0;
			idle_q        <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			present_s1  <= armed_q[cnt_q];
			idx_s1      <= cnt_q;

			if (commit || (accept && func == ntsel_pkg::FUNC_ARM)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (arm_hit) begin
				armed_q[ch_idx] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == ntsel_pkg::FUNC_ARM) begin
							now_time_q  <= global_time_q;
							fired_q     <= '0;
							idle_q      <= 1'b0;
						end else begin
							cnt_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q == CH_W'(CHANNELS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) begin
						if (none_armed) begin
							now_time_q <= global_time_q;
							fired_q    <= '0;
							idle_q     <= 1'b1;
						end else begin
							global_time_q <= best;
							armed_q       <= armed_q & ~ties;
							now_time_q    <= best;
							fired_q       <= fired_c;
							idle_q        <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign now_time   = now_time_q;
	assign fired_mask = fired_q;
	assign idle       = idle_q;

	// time never runs backwards: every armed deadline is at or after it
	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> global_time_q >= $past(global_time_q))
		else $error("global time decreased");

	// read data only arrives while an advance is being scanned
	a_sample_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("scan sample outside advance");

	// a committed advance that fired leaves those channels disarmed
	a_fired_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !none_armed |=> (armed_q & $past(ties)) == '0)
		else $error("fired channel still armed");

	// an idle result never carries fire bits
	a_idle_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && idle_q |-> fired_q == '0)
		else $error("idle result with fire bits");

endmodule
